/* rtl/dps_pkg.sv */
// Package for the delayed pulse scheduler: sizes, register map, reset values and shared types.
`timescale 1ns / 1ps

package dps_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int FRAME_WIDTH = 32;

  localparam int TRIG_W  = 4;
  localparam int DELAY_W = 16;
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W   = CNT_W + TRIG_W;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_DELAY  = 1'b0;
  localparam logic REG_REPEAT = 1'b1;

  localparam logic [DELAY_W-1:0] DELAY_RESET  = 16'd16;
  localparam logic               REPEAT_RESET = 1'b1;

  localparam logic [TRIG_W-1:0] FIRE_MAX = 4'd15;

  typedef logic [FRAME_WIDTH-1:0] frame_t;
  typedef logic [TRIG_W-1:0]      trig_t;

  // Request from the pipeline to the slot bank for the beat being retired
  typedef struct packed {
    logic  step;
    logic  act;
    logic  one_shot;
    logic  en;
    trig_t triggers;
  } slot_ctrl_t;

  // Outcome of one beat as decided by the slot bank
  typedef struct packed {
    trig_t fire_count;
    trig_t dropped_count;
    logic  halt;
  } slot_stat_t;

endpackage

/* rtl/dps_slot_bank.sv */
// Slot bank of the delayed pulse scheduler: pending targets, firing match and free-slot allocation.
`timescale 1ns / 1ps

module dps_slot_bank (
  input  logic                clk,
  input  logic                rst_n,
  input  dps_pkg::slot_ctrl_t ctrl,
  input  dps_pkg::frame_t     now,
  input  dps_pkg::frame_t     target,
  output dps_pkg::slot_stat_t stat
);
  import dps_pkg::*;

  logic [SLOT_COUNT-1:0] slot_valid_r;
  logic [SLOT_COUNT-1:0] slot_valid_nxt;
  frame_t                slot_target_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] due;
  logic [SLOT_COUNT-1:0] first_due;
  logic [SLOT_COUNT-1:0] cleared;
  logic [SLOT_COUNT-1:0] after_fire;
  logic [SLOT_COUNT-1:0] free;
  logic [SLOT_COUNT-1:0] take;
  logic [SLOT_COUNT-1:0] below;
  logic [CNT_W-1:0]      rank     [SLOT_COUNT];
  logic [CNT_W-1:0]      fired;
  logic [CNT_W-1:0]      free_cnt;
  logic [CMP_W-1:0]      trig_ext;
  logic [CMP_W-1:0]      free_ext;
  logic [CMP_W-1:0]      fired_ext;
  logic [CMP_W-1:0]      drop_ext;
  logic                  halt;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      due[i] = slot_valid_r[i] && (slot_target_r[i] == now);
    end
    first_due = due & (~due + {{(SLOT_COUNT-1){1'b0}}, 1'b1});
    halt      = ctrl.act && ctrl.one_shot && (|due);
    cleared   = halt ? first_due : due;
    after_fire = ctrl.act ? (slot_valid_r & ~cleared) : slot_valid_r;
    free      = ~after_fire;

    // A free slot is taken when fewer free slots lie below it than triggers arrived
    for (int i = 0; i < SLOT_COUNT; i++) begin
      below   = free & ~({SLOT_COUNT{1'b1}} << i);
      rank[i] = CNT_W'($countones(below));
      take[i] = free[i] && ({{TRIG_W{1'b0}}, rank[i]} < {{CNT_W{1'b0}}, ctrl.triggers});
    end
    if (!(ctrl.act && ctrl.en && !halt)) begin
      take = '0;
    end
    slot_valid_nxt = after_fire | take;

    fired    = ctrl.act ? (halt ? CNT_W'(1) : CNT_W'($countones(due))) : '0;
    free_cnt = CNT_W'($countones(free));
    trig_ext = {{CNT_W{1'b0}}, ctrl.triggers};
    free_ext = {{TRIG_W{1'b0}}, free_cnt};
    fired_ext = {{TRIG_W{1'b0}}, fired};
    if (ctrl.act && ctrl.en && !halt && (trig_ext > free_ext)) begin
      drop_ext = trig_ext - free_ext;
    end else begin
      drop_ext = '0;
    end

    stat.fire_count    = (fired_ext > {{CNT_W{1'b0}}, FIRE_MAX}) ? FIRE_MAX
                                                                 : fired_ext[TRIG_W-1:0];
    stat.dropped_count = drop_ext[TRIG_W-1:0];
    stat.halt          = halt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (ctrl.step) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // Targets need no reset: a slot is only compared while its valid bit is set
  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (ctrl.step && take[i]) begin
        slot_target_r[i] <= target;
      end
    end
  end

endmodule

/* rtl/delayed_pulse_scheduler.sv */
// Top level of the delayed pulse scheduler: register port, frame counter and beat pipeline.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid / in_stall  in_trigger_count[3:0], in_enabled
//  out_      output     out_valid/out_stall  out_fire_count[3:0], out_dropped_count[3:0],
//                                            out_finished
//  config    APB        psel/penable/pready  paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One frame beat is accepted every clock cycle while in_stall is low. Each beat passes an
// input register and then a result register; the slot match, free-slot allocation and
// counter update all sit between those two registers.
// Reset is synchronous and active low; it clears the frame counter, all slot valid bits,
// the stopped flag and the pipeline, and loads delay_frames = 16, repeat_mode = 1.
// A stalled result holds the result register, and the input register then stalls the
// input channel only if it too holds a beat.

module delayed_pulse_scheduler (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  dps_pkg::trig_t           in_trigger_count,
  input  logic                     in_enabled,
  output logic                     out_valid,
  input  logic                     out_stall,
  output dps_pkg::trig_t           out_fire_count,
  output dps_pkg::trig_t           out_dropped_count,
  output logic                     out_finished,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [dps_pkg::ADDR_W-1:0] paddr,
  input  logic [dps_pkg::DATA_W-1:0] pwdata,
  output logic [dps_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import dps_pkg::*;

  // Configuration registers
  logic [DELAY_W-1:0] delay_r;
  logic               repeat_r;
  logic               cfg_wr;

  // Block state
  frame_t frame_r;
  logic   stopped_r;
  logic   stopped_nxt;

  // Input register stage
  logic  s1_vld_r;
  logic  s1_vld_nxt;
  trig_t s1_trig_r;
  logic  s1_en_r;

  // Result register stage
  logic  out_vld_r;
  logic  out_vld_nxt;
  trig_t out_fire_r;
  trig_t out_drop_r;
  logic  out_fin_r;

  logic       in_take;
  logic       out_free;
  logic       s1_go;
  logic       act;
  frame_t     target;
  slot_ctrl_t ctrl;
  slot_stat_t stat;

  // Register port. Writes land on the access phase; reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_DELAY:  prdata = {{(DATA_W-DELAY_W){1'b0}}, delay_r};
      REG_REPEAT: prdata = {{(DATA_W-1){1'b0}}, repeat_r};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RESET;
      repeat_r <= REPEAT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DELAY:  delay_r  <= pwdata[DELAY_W-1:0];
        REG_REPEAT: repeat_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Flow control. The result register frees up when empty or when its beat is taken;
  // the input register moves on whenever the result register can take its beat.
  assign out_free   = !out_vld_r || !out_stall;
  assign s1_go      = s1_vld_r && out_free;
  assign in_stall   = s1_vld_r && !out_free;
  assign in_take    = in_valid && !in_stall;
  assign s1_vld_nxt = in_take || (s1_vld_r && !s1_go);
  assign out_vld_nxt = s1_go || (out_vld_r && !out_free);

  // The block only acts while running and with a non-zero delay.
  assign act    = !stopped_r && (delay_r != '0);
  assign target = frame_r + {{(FRAME_WIDTH-DELAY_W){1'b0}}, delay_r};

  always_comb begin
    ctrl.step     = s1_go;
    ctrl.act      = act;
    ctrl.one_shot = !repeat_r;
    ctrl.en       = s1_en_r;
    ctrl.triggers = s1_trig_r;
  end

  dps_slot_bank u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .now    (frame_r),
    .target (target),
    .stat   (stat)
  );

  // A one-shot firing latches the stopped flag, and it reads back in the same beat.
  assign stopped_nxt = stopped_r || stat.halt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      stopped_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_go) begin
        frame_r   <= frame_r + FRAME_WIDTH'(1);
        stopped_r <= stopped_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_trig_r <= in_trigger_count;
      s1_en_r   <= in_enabled;
    end
    if (s1_go) begin
      out_fire_r <= stat.fire_count;
      out_drop_r <= stat.dropped_count;
      out_fin_r  <= stopped_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_fire_count    = out_fire_r;
  assign out_dropped_count = out_drop_r;
  assign out_finished      = out_fin_r;

endmodule

/* dv/tb.sv */
// Testbench for the delayed pulse scheduler: drives frame beats and checks every result beat.
`timescale 1ns / 1ps

// Each accepted input beat is one frame tick. As it is accepted, the testbench's own slot
// model works out that frame's outcome and queues it. Result beats are compared with the
// queue in order, field by field. Registers are only written over the APB port once the
// pipeline has drained, and every write is read back.
//
// The run goes through these phases:
//   - a short directed table under the reset settings;
//   - random phases with delays from one frame up to a few dozen frames;
//   - a drain, and then a phase with the delay at zero;
//   - a phase with the delay at its largest value, then a random phase at a short delay;
//   - a final phase in one-shot mode. The block stops for good here, so it comes last.
module tb;
  import dps_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int MAX_RND_DELAY = 40;
  // Two register stages sit between acceptance and result, so SETTLE_CYCLES is ample.
  localparam int SETTLE_CYCLES = 4;
  localparam int DIRECTED_ROWS = 20;

  typedef struct packed {
    trig_t fire;
    trig_t drop;
    logic  fin;
  } frame_outcome_t;

  // One directed frame beat. Where typed is set, the expected outcome is given in the row.
  typedef struct packed {
    trig_t          trig;
    logic           en;
    logic           typed;
    frame_outcome_t want;
  } stim_row_t;

  localparam frame_outcome_t NO_OUTCOME = '0;

  // Under the reset settings (delay 16, repeating), frame n is row n. The first row fills
  // all eight slots for frame 16, so every enabled trigger in between is dropped.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{4'd15, 1'b1, 1'b1, '{4'd0, 4'd7,  1'b0}},
    '{4'd15, 1'b1, 1'b1, '{4'd0, 4'd15, 1'b0}},
    '{4'd15, 1'b0, 1'b1, '{4'd0, 4'd0,  1'b0}},
    '{4'd0,  1'b1, 1'b1, '{4'd0, 4'd0,  1'b0}},
    '{4'd1,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd3,  1'b0, 1'b0, NO_OUTCOME},
    '{4'd8,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd0,  1'b0, 1'b0, NO_OUTCOME},
    '{4'd2,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd5,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd0,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd12, 1'b1, 1'b0, NO_OUTCOME},
    '{4'd7,  1'b0, 1'b0, NO_OUTCOME},
    '{4'd0,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd4,  1'b1, 1'b0, NO_OUTCOME},
    '{4'd10, 1'b1, 1'b0, NO_OUTCOME},
    // Frame 16: all eight slots fall due together.
    '{4'd0,  1'b1, 1'b1, '{4'd8, 4'd0,  1'b0}},
    // Frame 17: eight triggers refill every slot, and the ninth in frame 18 is dropped.
    '{4'd8,  1'b1, 1'b1, '{4'd0, 4'd0,  1'b0}},
    '{4'd1,  1'b1, 1'b1, '{4'd0, 4'd1,  1'b0}},
    '{4'd9,  1'b1, 1'b0, NO_OUTCOME}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  trig_t               in_trigger_count;
  logic                in_enabled;
  logic                out_valid;
  logic                out_stall;
  trig_t               out_fire_count;
  trig_t               out_dropped_count;
  logic                out_finished;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Slot model: its own copy of the frame counter, slots, stop flag and registers.
  frame_t              frame_now;
  logic                slot_busy [SLOT_COUNT];
  frame_t              slot_due  [SLOT_COUNT];
  logic                halted;
  logic [DELAY_W-1:0]  delay_cfg;
  logic                repeat_cfg;

  frame_outcome_t      expected_outcomes [$];
  int                  mismatches;
  int                  results_seen;
  int                  cycle_count;
  // When set, neither side idles, so that some stretches run back to back.
  logic                calm;

  delayed_pulse_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_trigger_count  (in_trigger_count),
    .in_enabled        (in_enabled),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fire_count    (out_fire_count),
    .out_dropped_count (out_dropped_count),
    .out_finished      (out_finished),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Works out one frame tick. Due slots fire first, lowest index first. In one-shot mode
  // the first slot to fire stops the block, and nothing else happens in that frame.
  // Then each enabled trigger takes the lowest free slot, or is dropped.
  function automatic frame_outcome_t schedule_frame(input trig_t trig, input logic en);
    frame_outcome_t res;
    frame_t         target;
    int             fired;
    int             dropped;
    logic           halt_now;
    logic           placed;
    fired    = 0;
    dropped  = 0;
    halt_now = 1'b0;
    if (!halted && delay_cfg != '0) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!halt_now && slot_busy[i] && slot_due[i] == frame_now) begin
          slot_busy[i] = 1'b0;
          fired++;
          if (!repeat_cfg) begin
            halted   = 1'b1;
            halt_now = 1'b1;
          end
        end
      end
      if (!halt_now && en) begin
        target = frame_now + frame_t'(delay_cfg);
        for (int k = 0; k < int'(trig); k++) begin
          placed = 1'b0;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!placed && !slot_busy[i]) begin
              slot_busy[i] = 1'b1;
              slot_due[i]  = target;
              placed       = 1'b1;
            end
          end
          if (!placed) dropped++;
        end
      end
    end
    frame_now = frame_now + frame_t'(1);
    res.fire = (fired > int'(FIRE_MAX)) ? FIRE_MAX : trig_t'(fired);
    res.drop = trig_t'(dropped);
    res.fin  = halted;
    return res;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Trigger counts are mostly small, so that slots are often free and do fire. The sparse
  // form keeps most slots free when the delay is too long for anything to fire.
  function automatic trig_t pick_trig(input logic sparse);
    int r;
    r = $urandom_range(0, 99);
    if (sparse) return (r < 10) ? trig_t'(1) : trig_t'(0);
    if (r < 40) return trig_t'(0);
    if (r < 75) return trig_t'(1);
    if (r < 90) return trig_t'($urandom_range(2, 4));
    return trig_t'($urandom_range(5, 15));
  endfunction

  // Result side: the stall pattern changes at the falling edge, with runs of random length.
  initial begin
    int stall_run;
    stall_run = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) begin
        out_stall <= 1'b1;
        stall_run--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < 20) stall_run = pick_gap();
      end
    end
  end

  // Result beats are taken at the rising edge and compared with the oldest expectation.
  always @(posedge clk) begin
    frame_outcome_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected: fire %0d drop %0d fin %0b",
                                  results_seen, out_fire_count, out_dropped_count,
                                  out_finished));
      end else begin
        want = expected_outcomes.pop_front();
        if (out_fire_count !== want.fire)
          report_mismatch($sformatf("result beat %0d fire_count: expected %0d, got %0d",
                                    results_seen, want.fire, out_fire_count));
        if (out_dropped_count !== want.drop)
          report_mismatch($sformatf("result beat %0d dropped_count: expected %0d, got %0d",
                                    results_seen, want.drop, out_dropped_count));
        if (out_finished !== want.fin)
          report_mismatch($sformatf("result beat %0d finished: expected %0b, got %0b",
                                    results_seen, want.fin, out_finished));
      end
    end
  end

  // Offers one frame beat after a random gap and holds it until it is taken. The slot
  // model runs at the edge where the beat is accepted, so frames are counted as the block
  // counts them.
  task automatic send_frame(input trig_t trig, input logic en, input logic typed,
                            input frame_outcome_t want);
    int             gap;
    frame_outcome_t got;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_trigger_count <= trig;
    in_enabled       <= en;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    got = schedule_frame(trig, en);
    expected_outcomes.push_back(typed ? want : got);
  endtask

  // Stops sending, waits for every outstanding result, then lets the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer: a setup phase, then an access phase that ends when pready is high.
  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic which);
    logic [DATA_W-1:0] back;
    logic [DATA_W-1:0] want;
    apb_xfer(1'b0, {which, 2'b00}, '0, back);
    want = (which == REG_DELAY) ? DATA_W'(delay_cfg) : DATA_W'(repeat_cfg);
    if (back !== want)
      report_mismatch($sformatf("register %0d read back: expected %0d, got %0d",
                                which, want, back));
  endtask

  // Registers only change while the pipeline is empty. Slots still pending keep their
  // targets across a change of delay.
  task automatic set_register(input logic which, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    wait_drained();
    apb_xfer(1'b1, {which, 2'b00}, value, unused);
    if (which == REG_DELAY) delay_cfg = value[DELAY_W-1:0];
    else repeat_cfg = value[0];
    check_register(which);
  endtask

  // Random frames. Halfway through, the sender holds off until every result is back.
  task automatic run_random(input int beats, input logic sparse);
    for (int n = 0; n < beats; n++) begin
      if (n == beats / 2) wait_drained();
      send_frame(pick_trig(sparse), ($urandom_range(0, 99) < 85), 1'b0, NO_OUTCOME);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_trigger_count = '0;
    in_enabled       = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mismatches       = 0;
    results_seen     = 0;
    calm             = 1'b0;
    frame_now        = '0;
    halted           = 1'b0;
    delay_cfg        = DELAY_RESET;
    repeat_cfg       = REPEAT_RESET;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_busy[i] = 1'b0;
      slot_due[i]  = '0;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The reset values should read back before anything is written.
    check_register(REG_DELAY);
    check_register(REG_REPEAT);

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_frame(DIRECTED[r].trig, DIRECTED[r].en, DIRECTED[r].typed, DIRECTED[r].want);

    // The shortest delay: a trigger fires in the very next frame. The slots filled at the
    // end of the directed table still wait for their old target.
    set_register(REG_DELAY, DATA_W'(1));
    run_random(150, 1'b0);

    repeat (4) begin
      set_register(REG_DELAY, DATA_W'($urandom_range(2, MAX_RND_DELAY)));
      set_register(REG_REPEAT, DATA_W'(1));
      calm = ($urandom_range(0, 3) == 0);
      run_random(160, 1'b0);
    end
    calm = 1'b0;

    // With the delay at zero nothing fires, so a slot still pending would miss its target
    // for good. Let every pending slot fire first, with disabled frames carrying noise.
    repeat (MAX_RND_DELAY + 2) send_frame(pick_trig(1'b0), 1'b0, 1'b0, NO_OUTCOME);
    set_register(REG_DELAY, DATA_W'(0));
    run_random(60, 1'b0);

    // At the largest delay nothing can come due within this run. The sparse triggers still
    // take a few slots for good, which leaves the later phases with fewer free slots.
    set_register(REG_DELAY, DATA_W'(16'hFFFF));
    run_random(30, 1'b1);

    set_register(REG_DELAY, DATA_W'($urandom_range(2, 12)));
    run_random(100, 1'b0);

    // One-shot mode: the first slot to fire stops the block for the rest of the run.
    // Several slots often fall due in that same frame, and only one of them may fire.
    set_register(REG_REPEAT, DATA_W'(0));
    set_register(REG_DELAY, DATA_W'($urandom_range(3, 10)));
    run_random(150, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dps_pkg.sv
rtl/dps_slot_bank.sv
rtl/delayed_pulse_scheduler.sv
dv/tb.sv
